// ===== sv/srr_pkg.sv =====
// Shared types, constants and helpers for the sequence/region reorder release block.
package srr_pkg;

  localparam int WIN_SEQS    = 4;   // sequences held in the window (power of two)
  localparam int ROW_W       = 2;   // bits of a window row index
  localparam int MAX_REGIONS = 8;
  localparam int RGN_W       = 3;   // bits of a region index within a row
  localparam int NUM_SLOTS   = WIN_SEQS * MAX_REGIONS;
  localparam int SLOT_W      = ROW_W + RGN_W;
  localparam int TAG_BITS    = 16;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = 5;   // release counter, counts 0..MAX_RESULTS-1
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_REGION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ    = 2'd2;

  typedef enum logic [2:0] {
    ACC_STORED     = 3'd0,
    ACC_REPLACED   = 3'd1,
    ACC_STALE      = 3'd2,
    ACC_BEYOND     = 3'd3,
    ACC_BAD_REGION = 3'd4
  } acc_status_t;

  typedef struct packed {
    logic [31:0] seq_number;
    logic [3:0]  region_number;
    logic [15:0] request_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  accept_status;
    logic        release_valid;
    logic [31:0] release_seq;
    logic [3:0]  release_region;
    logic [15:0] release_tag;
    logic        is_own_region;
    logic        last_result;
  } out_item_t;

  function automatic logic [SLOT_W-1:0] slot_addr(input logic [ROW_W-1:0] row,
                                                  input logic [RGN_W-1:0] rgn);
    return {row, rgn};
  endfunction

endpackage

// ===== sv/srr_tag_ram.sv =====
// Simple dual-port RAM with registered read data, holds stored request tags.
module srr_tag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/seq_region_reorder_release_core.sv =====
// Reorder buffer keyed by (sequence, region): requests are stored in a window of slots and
// released strictly in order, region 1..region_count of each sequence, then the next sequence.
// Tags live in a 32-entry RAM with registered read data; slot valid bits are flops. An item
// is accepted and stored in ST_IDLE, then each released entry passes ST_CHECK (valid check
// and RAM read) and ST_DATA (output load); when nothing is released, ST_CHECK loads a single
// empty result. ST_CHECK waits while the output register is stalled. At most 32 entries leave
// per item. The next item is accepted as soon as its predecessor's final result sits in the
// output register. A write to start_seq clears all slots.
module seq_region_reorder_release_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  srr_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output srr_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [srr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DATA} state_t;

  state_t                          state_r, state_nxt;
  logic [3:0]                      region_count_r, region_count_nxt;
  logic [3:0]                      own_region_r, own_region_nxt;
  logic [31:0]                     exp_seq_r, exp_seq_nxt;
  logic [3:0]                      exp_reg_r, exp_reg_nxt;
  logic [srr_pkg::ROW_W-1:0]       head_r, head_nxt;
  logic [srr_pkg::NUM_SLOTS-1:0]   valid_r, valid_nxt;
  logic [2:0]                      status_r, status_nxt;
  logic [srr_pkg::CNT_W-1:0]       rel_cnt_r, rel_cnt_nxt;
  logic [31:0]                     rel_seq_r, rel_seq_nxt;
  logic [3:0]                      rel_reg_r, rel_reg_nxt;
  logic                            rel_own_r, rel_own_nxt;
  logic                            last_r, last_nxt;
  logic                            out_valid_r, out_valid_nxt;
  srr_pkg::out_item_t              out_data_r, out_data_nxt;

  logic [3:0]                      cnt;
  logic                            in_accept;
  logic                            out_free;
  logic [srr_pkg::SLOT_W-1:0]      cur_idx;

  logic                            ram_we;
  logic [srr_pkg::SLOT_W-1:0]      ram_waddr;
  logic [srr_pkg::TAG_BITS-1:0]    ram_wdata;
  logic [srr_pkg::TAG_BITS-1:0]    ram_rdata;

  srr_tag_ram #(
    .WIDTH(srr_pkg::TAG_BITS),
    .DEPTH(srr_pkg::NUM_SLOTS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cur_idx),
    .rdata(ram_rdata)
  );

  // region_count used clamped to 1..MAX_REGIONS
  always_comb begin
    if (region_count_r == 4'd0) begin
      cnt = 4'd1;
    end else if (region_count_r > 4'(srr_pkg::MAX_REGIONS)) begin
      cnt = 4'(srr_pkg::MAX_REGIONS);
    end else begin
      cnt = region_count_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cur_idx   = srr_pkg::slot_addr(head_r, srr_pkg::RGN_W'(exp_reg_r - 4'd1));

  always_comb begin
    logic [31:0]                n_seq;
    logic [3:0]                 n_reg;
    logic [srr_pkg::ROW_W-1:0]  n_head;
    logic [srr_pkg::NUM_SLOTS-1:0] n_valid;
    logic [31:0]                ahead;
    logic [srr_pkg::ROW_W-1:0]  row;
    logic [srr_pkg::SLOT_W-1:0] sidx;
    logic [3:0]                 nreg;
    logic                       adv;
    logic [srr_pkg::SLOT_W-1:0] nidx;

    state_nxt        = state_r;
    region_count_nxt = region_count_r;
    own_region_nxt   = own_region_r;
    exp_seq_nxt      = exp_seq_r;
    exp_reg_nxt      = exp_reg_r;
    head_nxt         = head_r;
    valid_nxt        = valid_r;
    status_nxt       = status_r;
    rel_cnt_nxt      = rel_cnt_r;
    rel_seq_nxt      = rel_seq_r;
    rel_reg_nxt      = rel_reg_r;
    rel_own_nxt      = rel_own_r;
    last_nxt         = last_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = in_data.request_tag;

    n_seq   = exp_seq_r;
    n_reg   = exp_reg_r;
    n_head  = head_r;
    n_valid = valid_r;
    ahead   = '0;
    row     = '0;
    sidx    = '0;
    nreg    = exp_reg_r + 4'd1;
    adv     = 1'b0;
    nidx    = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          // region_count may have shrunk below the expected region: move to next sequence
          if (exp_reg_r > cnt) begin
            for (int r = 0; r < srr_pkg::MAX_REGIONS; r++) begin
              n_valid[srr_pkg::slot_addr(head_r, srr_pkg::RGN_W'(r))] = 1'b0;
            end
            n_seq  = exp_seq_r + 32'd1;
            n_reg  = 4'd1;
            n_head = head_r + srr_pkg::ROW_W'(1);
          end
          ahead = in_data.seq_number - n_seq;
          row   = n_head + ahead[srr_pkg::ROW_W-1:0];
          sidx  = srr_pkg::slot_addr(row, srr_pkg::RGN_W'(in_data.region_number - 4'd1));
          if (in_data.region_number == 4'd0 || in_data.region_number > cnt) begin
            status_nxt = srr_pkg::ACC_BAD_REGION;
          end else if (ahead[31]) begin
            status_nxt = srr_pkg::ACC_STALE;
          end else if (ahead >= 32'(srr_pkg::WIN_SEQS)) begin
            status_nxt = srr_pkg::ACC_BEYOND;
          end else if (ahead == 32'd0 && in_data.region_number < n_reg) begin
            status_nxt = srr_pkg::ACC_STALE;
          end else begin
            status_nxt    = n_valid[sidx] ? srr_pkg::ACC_REPLACED : srr_pkg::ACC_STORED;
            n_valid[sidx] = 1'b1;
            ram_we        = 1'b1;
            ram_waddr     = sidx;
          end
          exp_seq_nxt = n_seq;
          exp_reg_nxt = n_reg;
          head_nxt    = n_head;
          valid_nxt   = n_valid;
          rel_cnt_nxt = '0;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          if (valid_r[cur_idx]) begin
            // tag read issued on cur_idx this cycle
            rel_seq_nxt = exp_seq_r;
            rel_reg_nxt = exp_reg_r;
            rel_own_nxt = (exp_reg_r == own_region_r);
            n_valid[cur_idx] = 1'b0;
            adv = (nreg > cnt);
            if (adv) begin
              for (int r = 0; r < srr_pkg::MAX_REGIONS; r++) begin
                n_valid[srr_pkg::slot_addr(head_r, srr_pkg::RGN_W'(r))] = 1'b0;
              end
              exp_seq_nxt = exp_seq_r + 32'd1;
              exp_reg_nxt = 4'd1;
              head_nxt    = head_r + srr_pkg::ROW_W'(1);
              nidx = srr_pkg::slot_addr(head_r + srr_pkg::ROW_W'(1), '0);
            end else begin
              exp_reg_nxt = nreg;
              nidx = srr_pkg::slot_addr(head_r, srr_pkg::RGN_W'(exp_reg_r));
            end
            valid_nxt   = n_valid;
            last_nxt    = !n_valid[nidx] ||
                          (rel_cnt_r == srr_pkg::CNT_W'(srr_pkg::MAX_RESULTS - 1));
            rel_cnt_nxt = rel_cnt_r + srr_pkg::CNT_W'(1);
            state_nxt   = ST_DATA;
          end else begin
            // nothing to release: single empty result
            out_data_nxt               = '0;
            out_data_nxt.accept_status = status_r;
            out_data_nxt.last_result   = 1'b1;
            out_valid_nxt              = 1'b1;
            state_nxt                  = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        out_data_nxt.accept_status  = status_r;
        out_data_nxt.release_valid  = 1'b1;
        out_data_nxt.release_seq    = rel_seq_r;
        out_data_nxt.release_region = rel_reg_r;
        out_data_nxt.release_tag    = ram_rdata;
        out_data_nxt.is_own_region  = rel_own_r;
        out_data_nxt.last_result    = last_r;
        out_valid_nxt               = 1'b1;
        state_nxt                   = last_r ? ST_IDLE : ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        srr_pkg::CFG_REGION_COUNT: region_count_nxt = cfg_wdata[3:0];
        srr_pkg::CFG_OWN_REGION:   own_region_nxt   = cfg_wdata[3:0];
        srr_pkg::CFG_START_SEQ: begin
          exp_seq_nxt = cfg_wdata;
          exp_reg_nxt = 4'd1;
          head_nxt    = '0;
          valid_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      region_count_r <= 4'd1;
      own_region_r   <= 4'd1;
      exp_seq_r      <= '0;
      exp_reg_r      <= 4'd1;
      head_r         <= '0;
      valid_r        <= '0;
      rel_cnt_r      <= '0;
      last_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      region_count_r <= region_count_nxt;
      own_region_r   <= own_region_nxt;
      exp_seq_r      <= exp_seq_nxt;
      exp_reg_r      <= exp_reg_nxt;
      head_r         <= head_nxt;
      valid_r        <= valid_nxt;
      rel_cnt_r      <= rel_cnt_nxt;
      last_r         <= last_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    status_r   <= status_nxt;
    rel_seq_r  <= rel_seq_nxt;
    rel_reg_r  <= rel_reg_nxt;
    rel_own_r  <= rel_own_nxt;
    out_data_r <= out_data_nxt;
  end

  // output register must be free when the RAM data lands
  a_data_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |-> !out_valid_r)
    else $error("release data arrived while output register busy");

  a_check_reg_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (exp_reg_r >= 4'd1 && exp_reg_r <= cnt))
    else $error("expected region out of range during release");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_CHECK && rel_cnt_r == '0))
    else $error("accepted transaction did not start release scan");

endmodule

// ===== sim/srr_tb_pkg.sv =====
// Scoreboard for the reorder release block: in-order release prediction and result checking.
`timescale 1ns / 1ps

package srr_tb_pkg;
  import srr_pkg::*;

  class release_scoreboard;
    bit          slot_full [NUM_SLOTS];
    logic [15:0] slot_tag  [NUM_SLOTS];
    bit   [31:0] next_seq;
    bit   [3:0]  next_region;
    bit   [1:0]  head_row;
    bit   [3:0]  region_count;
    bit   [3:0]  own_region;
    bit   [31:0] start_seq;
    out_item_t   expected_releases [$];
    int          errors;
    int          requests;
    int          checked;
    int          run_len;
    int          longest_run;
    int          status_seen [5];

    function new();
      region_count = 4'd1;
      own_region   = 4'd1;
      start_seq    = '0;
      restart();
    endfunction

    function void restart();
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      next_seq    = start_seq;
      next_region = 4'd1;
      head_row    = '0;
    endfunction

    function int regions_in_use();
      if (region_count < 1) return 1;
      if (region_count > MAX_REGIONS) return MAX_REGIONS;
      return region_count;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_REGION_COUNT: region_count = value[3:0];
        CFG_OWN_REGION:   own_region   = value[3:0];
        CFG_START_SEQ: begin
          start_seq = value;
          restart();
        end
        default: ;
      endcase
    endfunction

    // leaving a sequence frees its whole row
    function void step_window();
      for (int r = 0; r < MAX_REGIONS; r++) slot_full[head_row * MAX_REGIONS + r] = 1'b0;
      next_region = 4'd1;
      next_seq    = next_seq + 32'd1;
      head_row    = head_row + 2'd1;
    endfunction

    function void note_request(in_item_t req);
      int          cnt;
      int          idx;
      int          n;
      bit   [31:0] ahead;
      acc_status_t status;
      out_item_t   res;
      out_item_t   prev;
      cnt = regions_in_use();
      requests++;
      if (next_region > cnt || next_region < 1) step_window();
      ahead = req.seq_number - next_seq;
      if (req.region_number < 1 || req.region_number > cnt) begin
        status = ACC_BAD_REGION;
      end else if (ahead >= 32'h8000_0000) begin
        status = ACC_STALE;
      end else if (ahead >= WIN_SEQS) begin
        status = ACC_BEYOND;
      end else if (ahead == 0 && req.region_number < next_region) begin
        status = ACC_STALE;
      end else begin
        idx = ((head_row + ahead) % WIN_SEQS) * MAX_REGIONS + req.region_number - 1;
        status = slot_full[idx] ? ACC_REPLACED : ACC_STORED;
        slot_full[idx] = 1'b1;
        slot_tag[idx]  = req.request_tag;
      end
      status_seen[status]++;

      // release run; each entry is queued once the next one is known
      n = 0;
      while (n < MAX_RESULTS) begin
        if (next_region > cnt || next_region < 1) step_window();
        idx = head_row * MAX_REGIONS + next_region - 1;
        if (!slot_full[idx]) break;
        if (n > 0) expected_releases.push_back(prev);
        res = '0;
        res.accept_status  = status;
        res.release_valid  = 1'b1;
        res.release_seq    = next_seq;
        res.release_region = next_region;
        res.release_tag    = slot_tag[idx];
        res.is_own_region  = (next_region == own_region);
        prev = res;
        slot_full[idx] = 1'b0;
        n++;
        next_region = next_region + 4'd1;
        if (next_region > cnt) step_window();
      end
      if (n == 0) begin
        prev = '0;
        prev.accept_status = status;
      end
      prev.last_result = 1'b1;
      expected_releases.push_back(prev);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_release(out_item_t got);
      out_item_t want;
      if (expected_releases.size() == 0) begin
        $error("result 0x%h arrived with nothing outstanding", got);
        errors++;
        return;
      end
      want = expected_releases.pop_front();
      checked++;
      field_check("accept_status", want.accept_status, got.accept_status);
      field_check("release_valid", want.release_valid, got.release_valid);
      field_check("release_seq", want.release_seq, got.release_seq);
      field_check("release_region", want.release_region, got.release_region);
      field_check("release_tag", want.release_tag, got.release_tag);
      field_check("is_own_region", want.is_own_region, got.is_own_region);
      field_check("last_result", want.last_result, got.last_result);
      if (got.release_valid === 1'b1) run_len++;
      if (got.last_result === 1'b1) begin
        if (run_len > longest_run) longest_run = run_len;
        run_len = 0;
      end
    endfunction

    function int pending();
      return expected_releases.size();
    endfunction
  endclass

endpackage

// ===== sim/tb.sv =====
// Testbench top for seq_region_reorder_release_core: directed and random traffic, scoreboarded.
`timescale 1ns / 1ps

module tb;
  import srr_pkg::*;
  import srr_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 85;
  localparam int DIRECTED_ITEMS = 25;
  localparam int SETTLE         = 4;
  localparam int QUIET_LIMIT    = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  release_scoreboard sb = new();
  logic              calm = 1'b0;
  int                quiet_cycles = 0;
  int                rand_sent = 0;
  int                phase = 0;
  bit [3:0]          count_plan [6] = '{4'd8, 4'd15, 4'd0, 4'd3, 4'd1, 4'd6};
  bit [3:0]          own_plan   [6] = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd5, 4'd3};

  seq_region_reorder_release_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // mostly short gaps, a few long ones; none during calm stretches
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_regions(bit [3:0] rc);
    if (rc < 1) return 1;
    if (rc > MAX_REGIONS) return MAX_REGIONS;
    return rc;
  endfunction

  // transaction monitors and quiet-cycle counter
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_release(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result side back-pressure
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // valid stays high on return so back-to-back transactions need no re-raise
  task automatic send_item(in_item_t item);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic req(bit [31:0] seq, bit [3:0] region, bit [15:0] tag);
    in_item_t item;
    item.seq_number    = seq;
    item.region_number = region;
    item.request_tag   = tag;
    send_item(item);
  endtask

  task automatic pause_until_drained(int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // keys of up to a full window in shuffled order, with some noise mixed in
  task automatic send_round(bit [31:0] base, int cnt, int width, bit head_last, bit drop_one);
    bit [31:0] key_seq [$];
    bit [3:0]  key_rgn [$];
    bit [31:0] ts;
    bit [3:0]  tr;
    int        j;
    int        drop;
    for (int d = 0; d < width; d++) begin
      for (int r = 1; r <= cnt; r++) begin
        key_seq.push_back(base + d);
        key_rgn.push_back(4'(r));
      end
    end
    for (int i = key_seq.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      ts = key_seq[i]; key_seq[i] = key_seq[j]; key_seq[j] = ts;
      tr = key_rgn[i]; key_rgn[i] = key_rgn[j]; key_rgn[j] = tr;
    end
    if (head_last) begin
      // holding back the head key lets the last transaction release the round's keys up to any dropped one
      for (int i = 0; i < key_seq.size(); i++) begin
        if (key_seq[i] == base && key_rgn[i] == 4'd1) j = i;
      end
      ts = key_seq[j]; key_seq[j] = key_seq[$]; key_seq[$] = ts;
      tr = key_rgn[j]; key_rgn[j] = key_rgn[$]; key_rgn[$] = tr;
    end
    drop = drop_one ? $urandom_range(0, key_seq.size() - 1) : -1;
    for (int i = 0; i < key_seq.size(); i++) begin
      if (i != drop) begin
        req(key_seq[i], key_rgn[i], 16'($urandom));
        rand_sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: req($urandom, 4'($urandom_range(0, 15)), 16'($urandom));
          1: begin
            j = $urandom_range(0, i);
            req(key_seq[j], key_rgn[j], 16'($urandom));
          end
          default: begin
            if ($urandom_range(0, 1) == 1) ts = base + $urandom_range(4, 7);
            else ts = base - $urandom_range(1, 3);
            req(ts, 4'($urandom_range(1, cnt)), 16'($urandom));
          end
        endcase
        rand_sent++;
      end
    end
  endtask

  initial begin
    bit [31:0] s;
    bit [31:0] base;
    bit [3:0]  rc;
    bit [3:0]  own;
    bit        stuck;
    bit        drop;
    bit        head_last;
    int        rounds;
    int        width;
    stuck = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: start just below the 32-bit wrap
    s = 32'hFFFF_FFFE;
    write_reg(CFG_REGION_COUNT, 32'd4);
    write_reg(CFG_OWN_REGION, 32'd2);
    write_reg(CFG_START_SEQ, s);
    req(s, 4'd2, 16'h0000);             // stored, head missing
    req(s, 4'd2, 16'hFFFF);             // duplicate key
    req(s, 4'd0, 16'h5A5A);             // region zero
    req(s, 4'd15, 16'hA5A5);            // region far out of range
    req(s, 4'd5, 16'h0F0F);             // one above region count
    req(s, 4'd1, 16'h1234);             // releases regions 1 and 2
    req(s, 4'd1, 16'h4321);             // same sequence, already passed
    req(s - 32'd1, 4'd3, 16'h1111);     // behind the release point
    req(s + 32'h8000_0000, 4'd3, 16'h2222);
    req(s + 32'h7FFF_FFFF, 4'd3, 16'h3333);
    req(s + 32'd4, 4'd1, 16'h4444);     // just past the window
    for (int r = 1; r <= 4; r++) req(s + 32'd1, 4'(r), 16'($urandom));
    req(s + 32'd2, 4'd2, 16'($urandom));
    req(s + 32'd3, 4'd4, 16'($urandom));
    req(s, 4'd4, 16'($urandom));
    req(s, 4'd3, 16'($urandom));        // run across the wrap, stops at a gap
    req(s + 32'd2, 4'd1, 16'($urandom));
    pause_until_drained(SETTLE);
    // drop the count below the pending region: next transaction skips ahead
    write_reg(CFG_REGION_COUNT, 32'd2);
    req(s + 32'd3, 4'd1, 16'($urandom));
    req(s + 32'd3, 4'd2, 16'($urandom));
    req(s + 32'd5, 4'd1, 16'($urandom));
    pause_until_drained(SETTLE);
    // restart with an entry still held
    write_reg(CFG_OWN_REGION, 32'd15);
    write_reg(CFG_START_SEQ, 32'd0);
    req(32'd0, 4'd2, 16'($urandom));
    req(32'd0, 4'd1, 16'($urandom));

    base = 32'd0;
    while (rand_sent < RANDOM_ITEMS) begin
      pause_until_drained(SETTLE);
      rc  = (phase < 6) ? count_plan[phase] : 4'($urandom_range(0, 15));
      own = (phase < 6) ? own_plan[phase] : 4'($urandom_range(0, 15));
      write_reg(CFG_REGION_COUNT, {28'd0, rc});
      write_reg(CFG_OWN_REGION, {28'd0, own});
      if (phase == 0 || stuck || $urandom_range(0, 1) == 1) begin
        if (phase == 0) base = 32'hFFFF_FFFF;
        else if (phase == 3) base = 32'd0;
        else base = $urandom;
        write_reg(CFG_START_SEQ, base);
      end
      stuck = 1'b0;
      rounds = $urandom_range(1, 3);
      for (int k = 0; k < rounds && rand_sent < RANDOM_ITEMS; k++) begin
        calm      = ($urandom_range(0, 3) == 0);
        width     = (phase == 0 && k == 0) ? WIN_SEQS : $urandom_range(1, WIN_SEQS);
        head_last = (phase == 0 && k == 0) || ($urandom_range(0, 3) == 0);
        drop      = (k == rounds - 1) && ($urandom_range(0, 4) == 0);
        send_round(base, clamp_regions(rc), width, head_last, drop);
        stuck = stuck | drop;
        base  = base + width;
      end
      calm = 1'b0;
      phase++;
    end

    pause_until_drained(10);
    $display("Run: %0d requests (%0d directed) over %0d random register settings, %0d results.",
             sb.requests, DIRECTED_ITEMS, phase, sb.checked);
    $display("Longest release run %0d; stored/replaced/stale/beyond/bad %0d/%0d/%0d/%0d/%0d.",
             sb.longest_run, sb.status_seen[ACC_STORED], sb.status_seen[ACC_REPLACED],
             sb.status_seen[ACC_STALE], sb.status_seen[ACC_BEYOND],
             sb.status_seen[ACC_BAD_REGION]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/srr_pkg.sv
sv/srr_tag_ram.sv
sv/seq_region_reorder_release_core.sv
sim/srr_tb_pkg.sv
sim/tb.sv
